FILE: sv/worst_fit_block_allocator_unit_assert.svh
// ---------------------------------------------------------------------------
// Allocator assertion macros
// Concurrent checks that compile away when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef WORST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define WORST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WFBA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wfba assertion failed");
// next-cycle implication
`define WFBA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wfba assertion failed");
`else
`define WFBA_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define WFBA_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/wfba_pkg.sv
// ---------------------------------------------------------------------------
// Allocator package
// Field widths, opcodes, status codes and shared types.
// ---------------------------------------------------------------------------
package wfba_pkg;

    localparam int MAP_DEPTH_DEF = 1024;
    localparam int OWNER_W       = 8;
    localparam int SIZE_W        = 11;
    localparam int POS_W         = 10;
    localparam int STATUS_W      = 2;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ALLOC_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ALLOC_FAIL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTHING    = 2'd3;

    // one map entry: owned flag plus owner id
    typedef struct packed {
        logic               owned;
        logic [OWNER_W-1:0] owner;
    } t_cell;

    // commands to the run tracker
    typedef struct packed {
        logic clear;
        logic step;
        logic free;
    } t_run_ctl;

endpackage

FILE: sv/worst_fit_block_allocator_unit.sv
// ---------------------------------------------------------------------------
// Worst-fit block allocator
// Cell map allocator: allocate from the longest free run, release by owner.
// ---------------------------------------------------------------------------
// Usage:
//   Raise start with i_opcode, i_owner_id and i_request_size; the request is
//   taken at a clock edge where start is high and busy is low. busy is high
//   while a request is worked and drops in the cycle the result shows on
//   o_status, o_block_start and o_block_end with o_valid high; the receiver
//   cannot stall it, so capture it in that cycle. A new request can be taken
//   in that same cycle.
// Sequence: an allocate of size zero fails with no scan. Other allocates
//   read every cell of the map one cell per cycle, close the last run, then
//   decide; with no room they fail, else they write the block into the cell
//   map one cell per cycle. A release reads every cell one cell per cycle
//   and frees those held by its owner.
// Reset: synchronous, active low. After reset a clearing pass writes every
//   cell free, with busy high; then the block is idle.
// ---------------------------------------------------------------------------
module worst_fit_block_allocator_unit #(
    parameter int MAP_DEPTH = wfba_pkg::MAP_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          i_opcode,
    input  logic [wfba_pkg::OWNER_W-1:0]  i_owner_id,
    input  logic [wfba_pkg::SIZE_W-1:0]   i_request_size,
    output logic                          busy,
    output logic                          o_valid,
    output logic [wfba_pkg::STATUS_W-1:0] o_status,
    output logic [wfba_pkg::POS_W-1:0]    o_block_start,
    output logic [wfba_pkg::POS_W-1:0]    o_block_end
);
    import wfba_pkg::*;

`include "worst_fit_block_allocator_unit_assert.svh"

    localparam int AW = $clog2(MAP_DEPTH);
    localparam int CW = (AW + 1 > SIZE_W) ? AW + 1 : SIZE_W;
    localparam logic [AW:0] DEPTH_C = (AW + 1)'(MAP_DEPTH);
    localparam logic [AW:0] LAST_C  = (AW + 1)'(MAP_DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_DECIDE,
        S_FILL,
        S_REL
    } t_state;

    t_state                r_state,  n_state;
    logic [AW:0]           r_cnt,    n_cnt;
    logic                  r_pv,     n_pv;
    logic [AW-1:0]         r_paddr,  n_paddr;
    logic [OWNER_W-1:0]    r_owner,  n_owner;
    logic [SIZE_W-1:0]     r_size,   n_size;
    logic [AW-1:0]         r_waddr,  n_waddr;
    logic [SIZE_W-1:0]     r_left,   n_left;
    logic                  r_found,  n_found;
    logic                  r_valid,  n_valid;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [POS_W-1:0]      r_start,  n_start;
    logic [POS_W-1:0]      r_end,    n_end;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_cell         mem_wdata;
    logic          mem_re;
    t_cell         rd_cell;
    t_run_ctl      run_ctl;
    logic [AW:0]   best_len;
    logic [AW-1:0] best_at;
    logic [CW-1:0] at_ext;
    logic [CW-1:0] end_ext;
    logic          cnt_end;
    logic          rel_hit;

    wfba_cell_ram #(
        .MAP_DEPTH (MAP_DEPTH),
        .AW        (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (rd_cell)
    );

    wfba_run_unit #(
        .MAP_DEPTH (MAP_DEPTH),
        .AW        (AW)
    ) u_run (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (run_ctl),
        .i_addr     (r_paddr),
        .o_best_len (best_len),
        .o_best_at  (best_at)
    );

    assign cnt_end = (r_cnt == DEPTH_C);
    assign rel_hit = r_pv && rd_cell.owned && (rd_cell.owner == r_owner);
    assign at_ext  = CW'(best_at);
    assign end_ext = at_ext + CW'(r_size) - CW'(1);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_pv      = 1'b0;
        n_paddr   = r_cnt[AW-1:0];
        n_owner   = r_owner;
        n_size    = r_size;
        n_waddr   = r_waddr;
        n_left    = r_left;
        n_found   = r_found;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_start   = r_start;
        n_end     = r_end;
        mem_we    = 1'b0;
        mem_waddr = r_paddr;
        mem_wdata = '0;
        mem_re    = 1'b0;
        run_ctl   = '0;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt[AW-1:0];
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == LAST_C) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_owner       = i_owner_id;
                    n_size        = i_request_size;
                    n_cnt         = '0;
                    n_found       = 1'b0;
                    run_ctl.clear = 1'b1;
                    if (i_opcode == OP_RELEASE) begin
                        n_state = S_REL;
                    end else if (i_request_size == '0) begin
                        n_valid  = 1'b1;
                        n_status = ST_ALLOC_FAIL;
                        n_start  = '0;
                        n_end    = '0;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                run_ctl.step = r_pv;
                run_ctl.free = !rd_cell.owned;
                if (cnt_end) begin
                    n_state = S_FLUSH;
                end else begin
                    mem_re = 1'b1;
                    n_pv   = 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                end
            end
            S_FLUSH: begin
                // close the run that reaches the map end
                run_ctl.step = 1'b1;
                run_ctl.free = 1'b0;
                n_state      = S_DECIDE;
            end
            S_DECIDE: begin
                if (CW'(best_len) >= CW'(r_size)) begin
                    n_waddr = best_at;
                    n_left  = r_size;
                    n_start = at_ext[POS_W-1:0];
                    n_end   = end_ext[POS_W-1:0];
                    n_state = S_FILL;
                end else begin
                    n_valid  = 1'b1;
                    n_status = ST_ALLOC_FAIL;
                    n_start  = '0;
                    n_end    = '0;
                    n_state  = S_IDLE;
                end
            end
            S_FILL: begin
                mem_we          = 1'b1;
                mem_waddr       = r_waddr;
                mem_wdata.owned = 1'b1;
                mem_wdata.owner = r_owner;
                n_waddr         = r_waddr + 1'b1;
                n_left          = r_left - 1'b1;
                if (r_left == SIZE_W'(1)) begin
                    n_valid  = 1'b1;
                    n_status = ST_ALLOC_OK;
                    n_state  = S_IDLE;
                end
            end
            S_REL: begin
                // free the cell read last cycle if this owner holds it
                if (rel_hit) begin
                    mem_we  = 1'b1;
                    n_found = 1'b1;
                end
                if (cnt_end) begin
                    n_valid  = 1'b1;
                    n_status = (r_found || rel_hit) ? ST_RELEASED : ST_NOTHING;
                    n_start  = '0;
                    n_end    = '0;
                    n_state  = S_IDLE;
                end else begin
                    mem_re = 1'b1;
                    n_pv   = 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_pv     <= 1'b0;
            r_found  <= 1'b0;
            r_valid  <= 1'b0;
            r_status <= ST_ALLOC_OK;
            r_start  <= '0;
            r_end    <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_pv     <= n_pv;
            r_found  <= n_found;
            r_valid  <= n_valid;
            r_status <= n_status;
            r_start  <= n_start;
            r_end    <= n_end;
        end
        r_paddr <= n_paddr;
        r_owner <= n_owner;
        r_size  <= n_size;
        r_waddr <= n_waddr;
        r_left  <= n_left;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_block_start = r_start;
    assign o_block_end   = r_end;

    `WFBA_ASSERT_IMP(a_valid_when_idle, i_clk, i_rst_n, o_valid, !busy)
    `WFBA_ASSERT_NXT(a_single_strobe, i_clk, i_rst_n, o_valid && !start, !o_valid)
    `WFBA_ASSERT_IMP(a_zero_pos_on_non_alloc, i_clk, i_rst_n, o_valid && (o_status != ST_ALLOC_OK), (o_block_start == '0) && (o_block_end == '0))
    `WFBA_ASSERT_NXT(a_busy_after_start, i_clk, i_rst_n, start && !busy && !((i_opcode == OP_ALLOC) && (i_request_size == '0)), busy)

endmodule

FILE: sv/wfba_cell_ram.sv
// ---------------------------------------------------------------------------
// Allocator cell map
// Simple dual-port memory, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module wfba_cell_ram #(
    parameter int MAP_DEPTH = wfba_pkg::MAP_DEPTH_DEF,
    parameter int AW        = $clog2(MAP_DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  wfba_pkg::t_cell i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output wfba_pkg::t_cell o_rdata
);
    import wfba_pkg::*;

    t_cell r_mem [MAP_DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/wfba_run_unit.sv
// ---------------------------------------------------------------------------
// Allocator run tracker
// Counts free runs one cell per step and keeps the longest, first found.
// ---------------------------------------------------------------------------
module wfba_run_unit #(
    parameter int MAP_DEPTH = wfba_pkg::MAP_DEPTH_DEF,
    parameter int AW        = $clog2(MAP_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wfba_pkg::t_run_ctl i_ctl,
    input  logic [AW-1:0]      i_addr,
    output logic [AW:0]        o_best_len,
    output logic [AW-1:0]      o_best_at
);
    import wfba_pkg::*;

    logic [AW:0]   r_run_len;
    logic [AW-1:0] r_run_at;
    logic [AW:0]   r_best_len;
    logic [AW-1:0] r_best_at;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_run_len  <= '0;
            r_run_at   <= '0;
            r_best_len <= '0;
            r_best_at  <= '0;
        end else if (i_ctl.step) begin
            if (i_ctl.free) begin
                if (r_run_len == '0) begin
                    r_run_at <= i_addr;
                end
                r_run_len <= r_run_len + 1'b1;
            end else begin
                // strict compare keeps the earlier run on a tie
                if (r_run_len > r_best_len) begin
                    r_best_len <= r_run_len;
                    r_best_at  <= r_run_at;
                end
                r_run_len <= '0;
            end
        end
    end

    assign o_best_len = r_best_len;
    assign o_best_at  = r_best_at;

endmodule
